FILE: sv/isbr_pkg.sv
// Shared types and constants for the independent set best response unit.
package isbr_pkg;

    localparam int unsigned MAX_NODES   = 64;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned COUNT_W     = 7;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd64;

    localparam logic OP_ADD_EDGE = 1'b0;
    localparam logic OP_TURN     = 1'b1;

    typedef logic [MAX_NODES-1:0] t_row;
    typedef logic [IDX_W-1:0]     t_idx;

    typedef struct packed {
        logic opcode;
        t_idx vertex_a;
        t_idx vertex_b;
    } t_in;

    typedef struct packed {
        logic in_set;
        logic evaluated;
        logic converged;
        logic bad_index;
    } t_out;

endpackage

FILE: sv/independent_set_best_response_unit.sv
// Top level: adjacency memory, vertex flags and the best response pipeline.
//
//   Channel   Direction  Handshake                    Payload
//   in        sink       i_in_valid / o_in_stall      i_in_data  (opcode, vertex_a, vertex_b)
//   out       source     o_out_valid / i_out_stall    o_out_data (in_set, evaluated, converged,
//                                                                 bad_index)
//   cfg       sink       i_cfg_we                     i_cfg_data (vertex_count)
//
// One beat is taken every cycle while the output does not stall; each beat passes through
// the registered read of the adjacency memory and then the result register.
// Edge adds write the adjacency memory at acceptance; turns update the flags when they
// leave the row register, so every turn sees all earlier beats.
// Reset is synchronous and active low; per-row valid bits make the matrix read as empty
// at once, so there is no clearing pass. A stall on the output holds both stages and
// raises o_in_stall only when both are full.
module independent_set_best_response_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  isbr_pkg::t_in                        i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output isbr_pkg::t_out                       o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [isbr_pkg::COUNT_W-1:0]         i_cfg_data
);
    import isbr_pkg::*;

    // Configuration
    logic [COUNT_W-1:0] r_vertex_count;
    logic [COUNT_W-1:0] w_used;
    t_row               w_need;

    // Adjacency memory, split in two banks so an edge add writes each bank at one row.
    // Bank lo holds bit b of row a, bank hi holds bit a of row b; a row is their OR.
    t_row               r_adj_lo [MAX_NODES];
    t_row               r_adj_hi [MAX_NODES];
    logic [MAX_NODES-1:0] r_vld_lo;
    logic [MAX_NODES-1:0] r_vld_hi;

    // Stage one: the accepted beat and its adjacency row
    logic               r_s1_valid;
    t_in                r_s1_item;
    logic               r_s1_bad;
    t_row               r_rd_lo;
    t_row               r_rd_hi;
    logic               r_rd_vld_lo;
    logic               r_rd_vld_hi;

    // Vertex flags
    t_row               r_member;
    t_row               r_checked;
    t_row               n_member;
    t_row               n_checked;

    // Result register
    logic               r_out_valid;
    t_out               r_out_data;
    t_out               w_res;

    logic               w_accept;
    logic               w_s1_adv;
    logic               w_bad_in;
    logic               w_edge_wr;
    logic               w_turn_upd;
    t_row               w_neigh;
    logic               w_busy;
    logic               w_now;
    logic               w_old;

    assign w_used = (r_vertex_count > COUNT_MAX) ? COUNT_MAX : r_vertex_count;
    assign w_need = (w_used >= COUNT_MAX) ? '1
                                          : ((t_row'(1) << w_used) - t_row'(1));

    assign w_s1_adv   = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !w_s1_adv;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_bad_in = ({1'b0, i_in_data.vertex_a} >= w_used)
                   || ((i_in_data.opcode == OP_ADD_EDGE)
                       && ({1'b0, i_in_data.vertex_b} >= w_used));
    assign w_edge_wr = w_accept && (i_in_data.opcode == OP_ADD_EDGE) && !w_bad_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // Memory writes and registered reads
    always_ff @(posedge i_clk) begin
        if (w_edge_wr) begin
            if (r_vld_lo[i_in_data.vertex_a]) begin
                r_adj_lo[i_in_data.vertex_a][i_in_data.vertex_b] <= 1'b1;
            end else begin
                r_adj_lo[i_in_data.vertex_a] <= t_row'(1) << i_in_data.vertex_b;
            end
            if (r_vld_hi[i_in_data.vertex_b]) begin
                r_adj_hi[i_in_data.vertex_b][i_in_data.vertex_a] <= 1'b1;
            end else begin
                r_adj_hi[i_in_data.vertex_b] <= t_row'(1) << i_in_data.vertex_a;
            end
        end
        if (w_accept) begin
            r_rd_lo     <= r_adj_lo[i_in_data.vertex_a];
            r_rd_hi     <= r_adj_hi[i_in_data.vertex_a];
            r_rd_vld_lo <= r_vld_lo[i_in_data.vertex_a];
            r_rd_vld_hi <= r_vld_hi[i_in_data.vertex_a];
            r_s1_item   <= i_in_data;
            r_s1_bad    <= w_bad_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_lo <= '0;
            r_vld_hi <= '0;
        end else if (w_edge_wr) begin
            r_vld_lo[i_in_data.vertex_a] <= 1'b1;
            r_vld_hi[i_in_data.vertex_b] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Best response for the vertex in stage one
    assign w_neigh = (r_rd_vld_lo ? r_rd_lo : '0) | (r_rd_vld_hi ? r_rd_hi : '0);
    assign w_busy  = |(w_neigh & r_member);
    assign w_now   = !w_busy;
    assign w_old   = r_member[r_s1_item.vertex_a];
    assign w_turn_upd = w_s1_adv && (r_s1_item.opcode == OP_TURN) && !r_s1_bad;

    always_comb begin
        w_res     = '0;
        n_member  = r_member;
        n_checked = r_checked;
        if (r_s1_bad) begin
            w_res.bad_index = 1'b1;
        end else if (r_s1_item.opcode == OP_TURN) begin
            if (r_checked[r_s1_item.vertex_a]) begin
                w_res.converged = &(r_checked | ~w_need);
                w_res.in_set    = w_old;
            end else begin
                n_member[r_s1_item.vertex_a]  = w_now;
                n_checked[r_s1_item.vertex_a] = 1'b1;
                // A change of membership reopens every neighbor, the vertex itself on a
                // self loop included.
                if (w_now != w_old) begin
                    n_checked = n_checked & ~w_neigh;
                end
                w_res.evaluated = 1'b1;
                w_res.in_set    = w_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member  <= '0;
            r_checked <= '0;
        end else if (w_turn_upd) begin
            r_member  <= n_member;
            r_checked <= n_checked;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out_data <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_bad_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.bad_index)
        |-> !(o_out_data.in_set || o_out_data.evaluated || o_out_data.converged))
        else $error("flagged beat carries other result bits");

    a_conv_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.converged && o_out_data.evaluated))
        else $error("converged reported on an evaluating turn");

    a_member_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_turn_upd |=> (r_member[$past(r_s1_item.vertex_a)] == $past(w_res.in_set)))
        else $error("membership flag differs from reported in_set");

    a_eval_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_turn_upd && w_res.evaluated && (w_now == w_old))
        |=> r_checked[$past(r_s1_item.vertex_a)])
        else $error("evaluated vertex left unchecked without a change");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

endmodule
